// ===== hw/rtl/tha_pkg.sv =====
package tha_pkg;

    localparam int COORD_WIDTH     = 16;
    localparam int ANGLE_FRAC_BITS = 13;
    localparam int ITERATIONS      = 16;

    localparam int TOUCH_W = 12;
    localparam int CFG_W   = 12;
    localparam int HEAD_W  = 16;

    // centred difference: 13-bit touch offset minus a COORD_WIDTH position
    localparam int DIFF_W = ((COORD_WIDTH > TOUCH_W + 1) ? COORD_WIDTH : TOUCH_W + 1) + 1;
    localparam int MAG_W  = DIFF_W - 1;
    localparam int PRE_SHIFT = 24;
    // sign bit plus two bits of CORDIC gain growth
    localparam int XY_W  = MAG_W + PRE_SHIFT + 3;
    localparam int Z_W   = 33;
    localparam int SH_W  = (ITERATIONS > 1) ? $clog2(ITERATIONS) : 1;
    localparam int ROUND_SHIFT = 30 - ANGLE_FRAC_BITS;

    localparam logic [Z_W-1:0] PI_Q30      = 33'd3373259426;
    localparam logic [Z_W-1:0] HALF_PI_Q30 = 33'd1686629713;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_HEIGHT = 1'd1;
    localparam logic [CFG_W-1:0] HALF_WIDTH_RST  = 12'd320;
    localparam logic [CFG_W-1:0] HALF_HEIGHT_RST = 12'd240;

    typedef struct packed {
        logic zero;
        logic dx_neg;
        logic dy_neg;
        logic ax_zero;
        logic ay_zero;
    } tha_side_t;

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        tha_side_t              side;
    } tha_cell_t;

    // atan(2^-i) in Q30
    function automatic logic signed [Z_W-1:0] atan_q30(input int i);
        logic signed [Z_W-1:0] v;
        case (i)
            0:  v = 33'sd843314857;
            1:  v = 33'sd497837829;
            2:  v = 33'sd263043837;
            3:  v = 33'sd133525159;
            4:  v = 33'sd67021687;
            5:  v = 33'sd33543516;
            6:  v = 33'sd16775851;
            7:  v = 33'sd8388437;
            8:  v = 33'sd4194283;
            9:  v = 33'sd2097149;
            10: v = 33'sd1048576;
            11: v = 33'sd524288;
            12: v = 33'sd262144;
            13: v = 33'sd131072;
            14: v = 33'sd65536;
            15: v = 33'sd32768;
            16: v = 33'sd16384;
            17: v = 33'sd8192;
            18: v = 33'sd4096;
            19: v = 33'sd2048;
            20: v = 33'sd1024;
            21: v = 33'sd512;
            22: v = 33'sd256;
            23: v = 33'sd128;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== hw/rtl/tha_if.sv =====
interface tha_in_if
    import tha_pkg::*;
();
    logic                          valid;
    logic                          ready;
    logic [TOUCH_W-1:0]            touch_x;
    logic [TOUCH_W-1:0]            touch_y;
    logic signed [COORD_WIDTH-1:0] pos_x;
    logic signed [COORD_WIDTH-1:0] pos_y;

    modport source (output valid, output touch_x, output touch_y, output pos_x,
                    output pos_y, input ready);
    modport sink   (input valid, input touch_x, input touch_y, input pos_x,
                    input pos_y, output ready);
endinterface

interface tha_out_if
    import tha_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [HEAD_W-1:0] heading;
    logic                     zero_vector;

    modport source (output valid, output heading, output zero_vector, input ready);
    modport sink   (input valid, input heading, input zero_vector, output ready);
endinterface

// ===== hw/rtl/touch_to_heading_angle.sv =====
// Heading angle from an object position to a screen touch point.
// Input channel "sample" carries touch_x/touch_y in screen pixels and the
// object pos_x/pos_y in centred coordinates; output channel "result" carries
// heading (radians, Q3.13, -pi..pi) and zero_vector. Both use valid/ready.
// Configuration: cfg_we/cfg_index/cfg_data write half_width (index 0) and
// half_height (index 1); write them only while no word is in flight.
// From accept to result valid, a word passes one centring stage, one cell
// per CORDIC iteration and one output stage. A new word is accepted every
// cycle unless every stage is full; each stage is a register with its own
// valid bit. A stalled receiver holds the output register; words upstream
// keep advancing into empty stages, so sample.ready drops only once every
// stage is full. Reset empties the pipeline and sets the centre to 320, 240.
module touch_to_heading_angle
    import tha_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    tha_in_if.sink               sample,
    tha_out_if.source            result
);

    logic [CFG_W-1:0] half_width_reg, half_width_next;
    logic [CFG_W-1:0] half_height_reg, half_height_next;

    tha_cell_t cdata  [ITERATIONS+1];
    logic      cvalid [ITERATIONS+1];
    logic      cready [ITERATIONS+1];

    always_comb
    begin
        half_width_next  = half_width_reg;
        half_height_next = half_height_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_HALF_WIDTH:  half_width_next  = cfg_data;
                CFG_HALF_HEIGHT: half_height_next = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_width_reg  <= HALF_WIDTH_RST;
            half_height_reg <= HALF_HEIGHT_RST;
        end
        else
        begin
            half_width_reg  <= half_width_next;
            half_height_reg <= half_height_next;
        end
    end

    tha_prep u_prep (
        .clk         (clk),
        .rst_n       (rst_n),
        .half_width  (half_width_reg),
        .half_height (half_height_reg),
        .sample      (sample),
        .down_valid  (cvalid[0]),
        .down_ready  (cready[0]),
        .down_data   (cdata[0])
    );

    for (genvar i = 0; i < ITERATIONS; i++)
    begin : g_cell
        tha_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .shift      (SH_W'(i)),
            .angle      (atan_q30(i)),
            .up_valid   (cvalid[i]),
            .up_ready   (cready[i]),
            .up_data    (cdata[i]),
            .down_valid (cvalid[i+1]),
            .down_ready (cready[i+1]),
            .down_data  (cdata[i+1])
        );
    end

    tha_post u_post (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (cvalid[ITERATIONS]),
        .up_ready (cready[ITERATIONS]),
        .up_data  (cdata[ITERATIONS]),
        .result   (result)
    );

    a_zero_heading: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.zero_vector |-> result.heading == '0)
        else $error("zero vector word with nonzero heading");

    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !cvalid[0] |-> sample.ready)
        else $error("input stalled while centring stage is empty");

    a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
        result.ready |-> sample.ready)
        else $error("input stalled while receiver is ready");

endmodule

// ===== hw/rtl/tha_prep.sv =====
module tha_prep
    import tha_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic [CFG_W-1:0] half_width,
    input  logic [CFG_W-1:0] half_height,
    tha_in_if.sink          sample,
    output logic            down_valid,
    input  logic            down_ready,
    output tha_cell_t       down_data
);

    logic                     valid_reg, valid_next;
    tha_cell_t                data_reg, data_next;
    logic                     load;
    logic signed [DIFF_W-1:0] dx, dy;
    logic [MAG_W-1:0]         ax, ay;

    assign load         = !valid_reg || down_ready;
    assign sample.ready = load;
    assign down_valid   = valid_reg;
    assign down_data    = data_reg;

    always_comb
    begin
        dx = $signed({{(DIFF_W-TOUCH_W){1'b0}}, sample.touch_x})
           - $signed({{(DIFF_W-CFG_W){1'b0}}, half_width})
           - $signed({{(DIFF_W-COORD_WIDTH){sample.pos_x[COORD_WIDTH-1]}}, sample.pos_x});
        dy = $signed({{(DIFF_W-CFG_W){1'b0}}, half_height})
           - $signed({{(DIFF_W-TOUCH_W){1'b0}}, sample.touch_y})
           - $signed({{(DIFF_W-COORD_WIDTH){sample.pos_y[COORD_WIDTH-1]}}, sample.pos_y});
        ax = dx[DIFF_W-1] ? MAG_W'(-dx) : MAG_W'(dx);
        ay = dy[DIFF_W-1] ? MAG_W'(-dy) : MAG_W'(dy);

        data_next.x            = XY_W'({ax, {PRE_SHIFT{1'b0}}});
        data_next.y            = XY_W'({ay, {PRE_SHIFT{1'b0}}});
        data_next.z            = '0;
        data_next.side.zero    = (ax == '0) && (ay == '0);
        data_next.side.dx_neg  = dx[DIFF_W-1];
        data_next.side.dy_neg  = dy[DIFF_W-1];
        data_next.side.ax_zero = (ax == '0);
        data_next.side.ay_zero = (ay == '0);

        valid_next = load ? sample.valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load && sample.valid)
            data_reg <= data_next;
    end

endmodule

// ===== hw/rtl/tha_cell.sv =====
module tha_cell
    import tha_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [SH_W-1:0]       shift,
    input  logic signed [Z_W-1:0] angle,
    input  logic                  up_valid,
    output logic                  up_ready,
    input  tha_cell_t             up_data,
    output logic                  down_valid,
    input  logic                  down_ready,
    output tha_cell_t             down_data
);

    logic                   valid_reg, valid_next;
    tha_cell_t              data_reg, data_next;
    logic                   load;
    logic signed [XY_W-1:0] xs, ys;

    assign load       = !valid_reg || down_ready;
    assign up_ready   = load;
    assign down_valid = valid_reg;
    assign down_data  = data_reg;

    always_comb
    begin
        xs = up_data.x >>> shift;
        ys = up_data.y >>> shift;
        data_next      = up_data;
        // rotate toward the x axis
        if (!up_data.y[XY_W-1])
        begin
            data_next.x = up_data.x + ys;
            data_next.y = up_data.y - xs;
            data_next.z = up_data.z + angle;
        end
        else
        begin
            data_next.x = up_data.x - ys;
            data_next.y = up_data.y + xs;
            data_next.z = up_data.z - angle;
        end
        valid_next = load ? up_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load && up_valid)
            data_reg <= data_next;
    end

endmodule

// ===== hw/rtl/tha_post.sv =====
module tha_post
    import tha_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       up_valid,
    output logic       up_ready,
    input  tha_cell_t  up_data,
    tha_out_if.source  result
);

    logic              valid_reg, valid_next;
    logic [HEAD_W-1:0] heading_reg, heading_next;
    logic              zero_reg, zero_next;
    logic              load;
    logic [Z_W-1:0]    a_clamp, a_sel, a_quad, a_round;
    logic [HEAD_W-1:0] mag;

    assign load               = !valid_reg || result.ready;
    assign up_ready           = load;
    assign result.valid       = valid_reg;
    assign result.heading     = $signed(heading_reg);
    assign result.zero_vector = zero_reg;

    always_comb
    begin
        if (up_data.z[Z_W-1])
            a_clamp = '0;
        else if (up_data.z > HALF_PI_Q30)
            a_clamp = HALF_PI_Q30;
        else
            a_clamp = up_data.z;

        // axis-aligned vectors bypass the iteration result
        if (up_data.side.ay_zero)
            a_sel = '0;
        else if (up_data.side.ax_zero)
            a_sel = HALF_PI_Q30;
        else
            a_sel = a_clamp;

        a_quad  = up_data.side.dx_neg ? (PI_Q30 - a_sel) : a_sel;
        a_round = a_quad + (Z_W'(1) << (ROUND_SHIFT - 1));
        mag     = HEAD_W'(a_round >> ROUND_SHIFT);

        if (up_data.side.zero)
        begin
            heading_next = '0;
            zero_next    = 1'b1;
        end
        else
        begin
            heading_next = up_data.side.dy_neg ? HEAD_W'(-mag) : mag;
            zero_next    = 1'b0;
        end

        valid_next = load ? up_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load && up_valid)
        begin
            heading_reg <= heading_next;
            zero_reg    <= zero_next;
        end
    end

endmodule

// ===== sim/touch_to_heading_angle_tb.sv =====
module touch_to_heading_angle_tb
    import tha_pkg::*;
;

    localparam int  CORDIC_PRE   = 24;
    localparam longint PI_FIX     = 64'd3373259426;
    localparam longint HALF_PI_FIX = 64'd1686629713;
    localparam int  STALL_CYCLES = 80;
    localparam int  DRAIN_CYCLES = ITERATIONS + 6;

    typedef struct packed {
        logic [TOUCH_W-1:0]            tx;
        logic [TOUCH_W-1:0]            ty;
        logic signed [COORD_WIDTH-1:0] px;
        logic signed [COORD_WIDTH-1:0] py;
    } touch_word_t;

    typedef struct packed {
        logic signed [HEAD_W-1:0] heading;
        logic                     zero_vector;
    } heading_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    tha_in_if  sample_ch ();
    tha_out_if result_ch ();

    touch_to_heading_angle dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sample    (sample_ch),
        .result    (result_ch)
    );

    always #2 clk = ~clk;

    // mirror of the centre registers
    logic [CFG_W-1:0] centre_x = HALF_WIDTH_RST;
    logic [CFG_W-1:0] centre_y = HALF_HEIGHT_RST;

    heading_t heading_q [$];
    int       mismatch_count = 0;
    bit       no_idle = 1'b0;
    int       hold_seq = 0;

    // atan(2^-i) in Q30
    longint atan_tab [24] = '{
        843314857, 497837829, 263043837, 133525159, 67021687,
        33543516, 16775851, 8388437, 4194283, 2097149,
        1048576, 524288, 262144, 131072, 65536, 32768,
        16384, 8192, 4096, 2048, 1024, 512, 256, 128
    };

    function automatic heading_t predict_heading(input touch_word_t w);
        longint   dx, dy, ax, ay, a, mag, h, x, y, z, xs, ys;
        heading_t r;
        dx = longint'(w.tx) - longint'(centre_x) - longint'(w.px);
        dy = longint'(centre_y) - longint'(w.ty) - longint'(w.py);
        ax = (dx < 0) ? -dx : dx;
        ay = (dy < 0) ? -dy : dy;
        if (dx == 0 && dy == 0) begin
            r.heading     = '0;
            r.zero_vector = 1'b1;
            return r;
        end
        if (ay == 0)
            a = 0;
        else if (ax == 0)
            a = HALF_PI_FIX;
        else
        begin
            x = ax <<< CORDIC_PRE;
            y = ay <<< CORDIC_PRE;
            z = 0;
            for (int i = 0; i < ITERATIONS && i < 24; i++)
            begin
                xs = x >>> i;
                ys = y >>> i;
                if (y >= 0)
                begin
                    x = x + ys;
                    y = y - xs;
                    z = z + atan_tab[i];
                end
                else
                begin
                    x = x - ys;
                    y = y + xs;
                    z = z - atan_tab[i];
                end
            end
            if (z < 0) z = 0;
            if (z > HALF_PI_FIX) z = HALF_PI_FIX;
            a = z;
        end
        if (dx < 0) a = PI_FIX - a;
        // round half up on the magnitude, then apply the sign
        mag = (a + (longint'(1) <<< (29 - ANGLE_FRAC_BITS))) >>> (30 - ANGLE_FRAC_BITS);
        h = (dy < 0) ? -mag : mag;
        r.heading     = h[HEAD_W-1:0];
        r.zero_vector = 1'b0;
        return r;
    endfunction

    function automatic touch_word_t random_word();
        touch_word_t w;
        int          pick, dx;
        pick = $urandom_range(99);
        w.tx = TOUCH_W'($urandom());
        w.ty = TOUCH_W'($urandom());
        if ($urandom_range(3) == 0)
        begin
            w.px = COORD_WIDTH'($urandom());
            w.py = COORD_WIDTH'($urandom());
        end
        else
        begin
            w.px = COORD_WIDTH'(int'($urandom_range(8191)) - 4096);
            w.py = COORD_WIDTH'(int'($urandom_range(8191)) - 4096);
        end
        if (pick >= 24 && pick < 30)
        begin
            w.tx = $urandom_range(1) ? '1 : '0;
            w.ty = $urandom_range(1) ? '1 : '0;
        end
        // steer toward vertical, horizontal, zero and diagonal vectors
        if (pick < 8)
            w.px = COORD_WIDTH'(int'(w.tx) - int'(centre_x));
        else if (pick < 16)
            w.py = COORD_WIDTH'(int'(centre_y) - int'(w.ty));
        else if (pick < 20)
        begin
            w.px = COORD_WIDTH'(int'(w.tx) - int'(centre_x));
            w.py = COORD_WIDTH'(int'(centre_y) - int'(w.ty));
        end
        else if (pick < 24)
        begin
            dx   = int'(w.tx) - int'(centre_x) - int'(w.px);
            w.py = COORD_WIDTH'(int'(centre_y) - int'(w.ty) + ($urandom_range(1) ? dx : -dx));
        end
        return w;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    task automatic send_word(input touch_word_t w);
        int gap;
        gap = 0;
        if (!no_idle && $urandom_range(99) < 7)
            gap = 1;
        if (gap > 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_ch.valid   <= 1'b1;
        sample_ch.touch_x <= w.tx;
        sample_ch.touch_y <= w.ty;
        sample_ch.pos_x   <= w.px;
        sample_ch.pos_y   <= w.py;
        do @(posedge clk); while (!sample_ch.ready);
    endtask

    // drop valid and let every word in flight come out
    task automatic settle();
        sample_ch.valid <= 1'b0;
        while (heading_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_centre(input logic [CFG_W-1:0] cx, input logic [CFG_W-1:0] cy);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_HALF_WIDTH;
        cfg_data  <= cx;
        @(posedge clk);
        cfg_index <= CFG_HALF_HEIGHT;
        cfg_data  <= cy;
        @(posedge clk);
        cfg_we   <= 1'b0;
        centre_x = cx;
        centre_y = cy;
    endtask

    task automatic test_directed_reset_centre();
        send_word('{12'd320, 12'd240, 16'sd0, 16'sd0});
        send_word('{12'd4095, 12'd240, 16'sd0, 16'sd0});
        send_word('{12'd0, 12'd240, 16'sd0, 16'sd0});
        send_word('{12'd320, 12'd0, 16'sd0, 16'sd0});
        send_word('{12'd320, 12'd4095, 16'sd0, 16'sd0});
        send_word('{12'd420, 12'd140, 16'sd0, 16'sd0});
        send_word('{12'd220, 12'd140, 16'sd0, 16'sd0});
        send_word('{12'd220, 12'd340, 16'sd0, 16'sd0});
        send_word('{12'd420, 12'd340, 16'sd0, 16'sd0});
        send_word('{12'd0, 12'd0, 16'sh8000, 16'sh8000});
        send_word('{12'd4095, 12'd4095, 16'sh7fff, 16'sh7fff});
        send_word('{12'd0, 12'd4095, 16'sh7fff, 16'sh8000});
        send_word('{12'd0, 12'd239, 16'sh7fff, 16'sd0});
        send_word('{12'd0, 12'd241, 16'sh7fff, 16'sd0});
        send_word('{12'd4095, 12'd0, 16'sd3775, 16'sd240});
        send_word('{12'd0, 12'd0, 16'sd100, 16'sd240});
        send_word('{12'd321, 12'd0, 16'sd0, 16'sh8000});
        send_word('{12'd4095, 12'd4095, 16'sh8000, 16'sh7fff});
        send_word('{12'd319, 12'd4095, 16'sd0, 16'sh7fff});
        send_word('{12'd4095, 12'd0, 16'sd0, 16'sd0});
        settle();
    endtask

    task automatic test_centre_sweep();
        logic [CFG_W-1:0] cx [8];
        logic [CFG_W-1:0] cy [8];
        cx = '{12'd1, 12'd2048, 12'd0, 12'd4095, 12'd1, 12'd2048, 12'd0, 12'd0};
        cy = '{12'd1, 12'd2048, 12'd0, 12'd4095, 12'd2048, 12'd1, 12'd0, 12'd0};
        cx[6] = CFG_W'($urandom_range(1, 2048));
        cy[6] = CFG_W'($urandom_range(1, 2048));
        cx[7] = CFG_W'($urandom());
        cy[7] = CFG_W'($urandom());
        for (int p = 0; p < 8; p++)
        begin
            set_centre(cx[p], cy[p]);
            repeat (55) send_word(random_word());
            settle();
        end
    endtask

    // hold the receiver off while words keep coming, so the pipe fills
    task automatic test_backpressure();
        set_centre(HALF_WIDTH_RST, HALF_HEIGHT_RST);
        no_idle = 1'b1;
        hold_seq++;
        repeat (60) send_word(random_word());
        no_idle = 1'b0;
        settle();
    endtask

    task automatic test_steady_stream();
        set_centre(CFG_W'($urandom_range(1, 2048)), CFG_W'($urandom_range(1, 2048)));
        no_idle = 1'b1;
        repeat (120) send_word(random_word());
        no_idle = 1'b0;
        repeat (40) send_word(random_word());
        settle();
    endtask

    initial
    begin
        int hold_left;
        int seen_seq;
        hold_left = 0;
        seen_seq  = 0;
        result_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_seq != seen_seq)
            begin
                seen_seq  = hold_seq;
                hold_left = STALL_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else if (no_idle)
                result_ch.ready <= 1'b1;
            else
                result_ch.ready <= ($urandom_range(99) >= 7);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && sample_ch.valid && sample_ch.ready)
            heading_q.push_back(predict_heading('{sample_ch.touch_x, sample_ch.touch_y,
                                                  sample_ch.pos_x, sample_ch.pos_y}));
    end

    always @(posedge clk)
    begin
        heading_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (heading_q.size() == 0)
                report_mismatch("word with nothing pending, heading",
                                longint'(result_ch.heading), longint'(0));
            else
            begin
                want = heading_q.pop_front();
                if (result_ch.heading !== want.heading)
                    report_mismatch("heading", longint'(result_ch.heading),
                                    longint'(want.heading));
                if (result_ch.zero_vector !== want.zero_vector)
                    report_mismatch("zero_vector", longint'(result_ch.zero_vector),
                                    longint'(want.zero_vector));
            end
        end
    end

    initial
    begin
        #1600000;
        $display("FAIL touch_to_heading_angle");
        $finish;
    end

    initial
    begin
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = CFG_HALF_WIDTH;
        cfg_data          = '0;
        sample_ch.valid   = 1'b0;
        sample_ch.touch_x = '0;
        sample_ch.touch_y = '0;
        sample_ch.pos_x   = '0;
        sample_ch.pos_y   = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_reset_centre();
        test_centre_sweep();
        test_backpressure();
        test_steady_stream();

        if (mismatch_count == 0)
            $display("PASS touch_to_heading_angle");
        else
            $display("FAIL touch_to_heading_angle");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/tha_pkg.sv
hw/rtl/tha_if.sv
hw/rtl/tha_prep.sv
hw/rtl/tha_cell.sv
hw/rtl/tha_post.sv
hw/rtl/touch_to_heading_angle.sv
sim/touch_to_heading_angle_tb.sv
